// ===== rtl/core/lcf_pkg.sv =====
package lcf_pkg;

    localparam int MAX_TAPS  = 7;
    localparam int HIST_LEN  = MAX_TAPS - 1;
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int PROD_W    = SAMPLE_W + COEF_W;
    localparam int RESULT_W  = 34;
    localparam int TAPS_W    = 3;
    localparam int STEP_W    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;
    localparam int HIST_W    = HIST_LEN * SAMPLE_W;
    localparam int HIST_DEPTH = 1;
    localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COEF_0    = CFG_IDX_W'(1);

    typedef logic [MAX_TAPS-1:0][COEF_W-1:0]  coef_arr_t;
    typedef logic [HIST_LEN-1:0][SAMPLE_W-1:0] hist_t;

    typedef struct packed {
        logic [MAX_TAPS-1:0][PROD_W-1:0] prod;
        logic                            last;
    } prod_beat_t;

    typedef struct packed {
        logic valid;
        logic flushing;
        logic we;
        logic fwd_sel;
    } fe_stat_t;

    // zero taps behaves as one, anything above MAX_TAPS saturates
    function automatic logic [TAPS_W-1:0] eff_taps(input logic [TAPS_W-1:0] t);
        logic [TAPS_W-1:0] r;
        r = t;
        if (t == '0)
            r = TAPS_W'(1);
        else if (t > TAPS_W'(MAX_TAPS))
            r = TAPS_W'(MAX_TAPS);
        return r;
    endfunction

endpackage

// ===== rtl/core/linear_convolution_fir_unit.sv =====
// Channel    Dir  Handshake                    Payload
// s_axis     in   s_axis_tvalid/tready         tdata[15:0] sample, tlast last
// m_axis     out  m_axis_tvalid/tready         tdata[33:0] result, tlast last_out
// cfg        in   cfg_valid/cfg_ready          cfg_index register, cfg_data value
//
// One sample per cycle while the output does not stall; a sample marked last holds
// the input while its T-1 flush outputs (T = taps in use) leave the history stage.
// Inputs pass the history stage, then product, pair-sum, quad-sum and result regs;
// the history RAM read-modify-write with forwarding sets the one-item-per-cycle loop.
// Reset clears the pipeline and the history (taps 5, coefficients 0).
// A stalled output backs up stage by stage; bubbles still fill.
module linear_convolution_fir_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [lcf_pkg::SAMPLE_W-1:0]        s_axis_tdata,  // [15:0] sample
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [lcf_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // [33:0] result, rest zero
    output logic                                m_axis_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lcf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lcf_pkg::CFG_W-1:0]           cfg_data
);
    import lcf_pkg::*;

    logic [TAPS_W-1:0]   tap_count_reg, tap_count_next;
    coef_arr_t           coef_reg, coef_next;
    logic [CFG_IDX_W-1:0] coef_sel;

    logic                fe_valid;
    logic                mac_ready;
    prod_beat_t          fe_beat;
    fe_stat_t            fe_stat;
    logic [RESULT_W-1:0] result;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        tap_count_next = tap_count_reg;
        coef_next      = coef_reg;
        coef_sel       = cfg_index - REG_COEF_0;
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_TAP_COUNT)
                tap_count_next = cfg_data[TAPS_W-1:0];
            else if (coef_sel < CFG_IDX_W'(MAX_TAPS))
                coef_next[coef_sel] = cfg_data[COEF_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= TAPS_W'(5);
            coef_reg      <= '0;
        end
        else
        begin
            tap_count_reg <= tap_count_next;
            coef_reg      <= coef_next;
        end
    end

    lcf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_sample (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .taps      (eff_taps(tap_count_reg)),
        .coefs     (coef_reg),
        .out_valid (fe_valid),
        .out_ready (mac_ready),
        .out_beat  (fe_beat),
        .stat      (fe_stat)
    );

    lcf_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fe_valid),
        .in_ready  (mac_ready),
        .in_beat   (fe_beat),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .result    (result),
        .last_out  (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_TDATA_W'(result);

`ifndef ASSERT_OFF
    a_flush_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        fe_stat.flushing |-> !s_axis_tready)
        else $error("input taken during flush");

    a_forward_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && fe_stat.we) |=> fe_stat.fwd_sel)
        else $error("history read on write edge not forwarded");

    a_flush_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        fe_stat.we |-> fe_stat.valid)
        else $error("history written with no item in stage");
`endif

endmodule

// ===== rtl/core/lcf_ram.sv =====
module lcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/lcf_front.sv =====
module lcf_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [lcf_pkg::SAMPLE_W-1:0]    in_sample,
    input  logic                            in_last,
    input  logic [lcf_pkg::TAPS_W-1:0]      taps,
    input  lcf_pkg::coef_arr_t              coefs,
    output logic                            out_valid,
    input  logic                            out_ready,
    output lcf_pkg::prod_beat_t             out_beat,
    output lcf_pkg::fe_stat_t               stat
);
    import lcf_pkg::*;

    localparam int RAM_AW = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

    logic                s1_valid_reg, s1_valid_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                fwd_sel_reg, fwd_sel_next;
    logic                ram_valid_reg, ram_valid_next;
    logic [SAMPLE_W-1:0] sample_reg, sample_next;
    logic                last_reg, last_next;
    hist_t               hist_fwd_reg, hist_fwd_next;

    hist_t               ram_rdata;
    hist_t               hist_cur;
    hist_t               hist_new;
    hist_t               wdata;
    logic [SAMPLE_W-1:0] x;
    logic                done;
    logic                fire;
    logic                leave;
    logic                accept;

    // history read at accept; the last written history is forwarded when the
    // write landed on the same edge as the read or the item is flushing
    lcf_ram #(
        .WIDTH (HIST_W),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (fire),
        .waddr (RAM_AW'(0)),
        .wdata (wdata),
        .re    (accept),
        .raddr (RAM_AW'(0)),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        hist_cur = fwd_sel_reg ? hist_fwd_reg : (ram_valid_reg ? ram_rdata : '0);
        x        = (step_reg == '0) ? sample_reg : '0;
        done     = !last_reg || (step_reg == STEP_W'(taps - TAPS_W'(1)));
        fire     = s1_valid_reg && out_ready;
        leave    = fire && done;
        in_ready = !s1_valid_reg || leave;
        accept   = in_valid && in_ready;

        hist_new[0] = x;
        for (int k = 1; k < HIST_LEN; k++)
        begin
            hist_new[k] = hist_cur[k-1];
        end
        // clear the line after the final output of a run
        wdata = (leave && last_reg) ? '0 : hist_new;

        out_beat.prod[0] = $signed(coefs[0]) * $signed(x);
        for (int k = 1; k < MAX_TAPS; k++)
        begin
            if (TAPS_W'(k) < taps)
                out_beat.prod[k] = $signed(coefs[k]) * $signed(hist_cur[k-1]);
            else
                out_beat.prod[k] = '0;
        end
        out_beat.last = last_reg && done;
        out_valid     = s1_valid_reg;

        s1_valid_next  = accept ? 1'b1 : (leave ? 1'b0 : s1_valid_reg);
        sample_next    = accept ? in_sample : sample_reg;
        last_next      = accept ? in_last : last_reg;
        step_next      = step_reg;
        if (accept)
            step_next = '0;
        else if (fire && !done)
            step_next = step_reg + STEP_W'(1);
        fwd_sel_next   = (accept || fire) ? fire : fwd_sel_reg;
        hist_fwd_next  = fire ? wdata : hist_fwd_reg;
        ram_valid_next = ram_valid_reg || fire;

        stat.valid    = s1_valid_reg;
        stat.flushing = s1_valid_reg && last_reg && !done;
        stat.we       = fire;
        stat.fwd_sel  = fwd_sel_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            step_reg      <= '0;
            fwd_sel_reg   <= 1'b0;
            ram_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            step_reg      <= step_next;
            fwd_sel_reg   <= fwd_sel_next;
            ram_valid_reg <= ram_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        last_reg     <= last_next;
        hist_fwd_reg <= hist_fwd_next;
    end

endmodule

// ===== rtl/core/lcf_mac.sv =====
module lcf_mac (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  lcf_pkg::prod_beat_t           in_beat,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lcf_pkg::RESULT_W-1:0]  result,
    output logic                          last_out
);
    import lcf_pkg::*;

    localparam int N3  = (MAX_TAPS + 1) / 2;
    localparam int N4  = (N3 + 1) / 2;
    localparam int S3W = PROD_W + 1;

    logic                v2_reg, v2_next, v3_reg, v3_next;
    logic                v4_reg, v4_next, v5_reg, v5_next;
    prod_beat_t          b2_reg, b2_next;
    logic [S3W-1:0]      s3_reg [N3];
    logic [S3W-1:0]      s3_next [N3];
    logic [RESULT_W-1:0] s4_reg [N4];
    logic [RESULT_W-1:0] s4_next [N4];
    logic [RESULT_W-1:0] res_reg, res_next;
    logic                l3_reg, l3_next, l4_reg, l4_next, l5_reg, l5_next;
    logic                r2, r3, r4, r5;

    always_comb
    begin
        r5       = !v5_reg || out_ready;
        r4       = !v4_reg || r5;
        r3       = !v3_reg || r4;
        r2       = !v2_reg || r3;
        in_ready = r2;

        v2_next = r2 ? in_valid : v2_reg;
        b2_next = (r2 && in_valid) ? in_beat : b2_reg;

        v3_next = r3 ? v2_reg : v3_reg;
        l3_next = (r3 && v2_reg) ? b2_reg.last : l3_reg;
        for (int j = 0; j < N3; j++)
        begin
            s3_next[j] = s3_reg[j];
            if (r3 && v2_reg)
            begin
                s3_next[j] = S3W'($signed(b2_reg.prod[2*j]));
                if (2*j + 1 < MAX_TAPS)
                    s3_next[j] = s3_next[j] + S3W'($signed(b2_reg.prod[2*j+1]));
            end
        end

        v4_next = r4 ? v3_reg : v4_reg;
        l4_next = (r4 && v3_reg) ? l3_reg : l4_reg;
        for (int j = 0; j < N4; j++)
        begin
            s4_next[j] = s4_reg[j];
            if (r4 && v3_reg)
            begin
                s4_next[j] = RESULT_W'($signed(s3_reg[2*j]));
                if (2*j + 1 < N3)
                    s4_next[j] = s4_next[j] + RESULT_W'($signed(s3_reg[2*j+1]));
            end
        end

        v5_next  = r5 ? v4_reg : v5_reg;
        l5_next  = (r5 && v4_reg) ? l4_reg : l5_reg;
        res_next = res_reg;
        if (r5 && v4_reg)
        begin
            res_next = s4_reg[0];
            for (int j = 1; j < N4; j++)
            begin
                res_next = res_next + s4_reg[j];
            end
        end

        out_valid = v5_reg;
        result    = res_reg;
        last_out  = l5_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
            v5_reg <= v5_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b2_reg  <= b2_next;
        s3_reg  <= s3_next;
        s4_reg  <= s4_next;
        res_reg <= res_next;
        l3_reg  <= l3_next;
        l4_reg  <= l4_next;
        l5_reg  <= l5_next;
    end

endmodule

// ===== sim/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lcf_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 10;
    localparam int MAX_REPORTS = 10;
    localparam int RAND_ITEMS_PER_MODE = 28;

    typedef enum logic {ROW_CFG, ROW_SMP} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [SAMPLE_W-1:0]    val;
        logic                   lst;
        logic                   chk;
        logic [RESULT_W-1:0]    want_res;
        logic                   want_lst;
    } stim_row_t;

    typedef struct {
        logic [RESULT_W-1:0] res;
        logic                lst;
    } conv_out_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [SAMPLE_W-1:0]    s_axis_tdata;   // [15:0] sample
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [33:0] result, [39:34] zero
    logic                   m_axis_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_data;

    // predictor state
    logic [TAPS_W-1:0]          taps_reg;
    logic signed [COEF_W-1:0]   coef_reg [MAX_TAPS];
    logic signed [SAMPLE_W-1:0] hist [HIST_LEN];

    conv_out_t conv_out_q [$];
    stim_row_t dir_tab [$];

    int fail_cnt = 0;
    int stall_cnt = 0;
    int send_idle_pct;
    int recv_idle_pct;

    linear_convolution_fir_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic stim_row_t r_cfg(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_W-1:0] val);
        stim_row_t r;
        r = '{ROW_CFG, idx, val, 1'b0, 1'b0, '0, 1'b0};
        return r;
    endfunction

    function automatic stim_row_t r_smp(input logic [SAMPLE_W-1:0] val, input logic lst,
                                        input logic chk = 1'b0,
                                        input logic [RESULT_W-1:0] want_res = '0,
                                        input logic want_lst = 1'b0);
        stim_row_t r;
        r = '{ROW_SMP, '0, val, lst, chk, want_res, want_lst};
        return r;
    endfunction

    // append a row to the directed table
    function automatic void add_row(input stim_row_t r);
        dir_tab.insert(dir_tab.size(), r);
    endfunction

    // append an expected output to the scoreboard
    function automatic void add_expect(input conv_out_t o);
        conv_out_q.insert(conv_out_q.size(), o);
    endfunction

    function automatic logic [15:0] rand_word();
        logic [15:0] w;
        case ($urandom_range(7))
            0: w = 16'h8000;
            1: w = 16'h7FFF;
            2: w = 16'h0000;
            3: w = 16'hFFFF;
            default: w = 16'($urandom);
        endcase
        return w;
    endfunction

    function automatic int taps_in_use();
        return (taps_reg == '0) ? 1 : int'(taps_reg);
    endfunction

    // one output of the tap chain, then shift the sample into the history
    function automatic logic [RESULT_W-1:0] tap_sum_shift(input logic signed [SAMPLE_W-1:0] cur);
        longint acc;
        int     ntaps;
        ntaps = taps_in_use();
        acc = longint'(coef_reg[0]) * longint'(cur);
        for (int k = 1; k < ntaps; k++)
            acc += longint'(coef_reg[k]) * longint'(hist[k-1]);
        for (int k = HIST_LEN - 1; k > 0; k--)
            hist[k] = hist[k-1];
        hist[0] = cur;
        return acc[RESULT_W-1:0];
    endfunction

    task automatic queue_results(input stim_row_t r);
        conv_out_t outs [$];
        conv_out_t o;
        int        ntaps;
        ntaps = taps_in_use();
        o.res = tap_sum_shift(r.val);
        o.lst = r.lst && (ntaps == 1);
        outs.insert(outs.size(), o);
        if (r.lst)
        begin
            // flush with zeros, mark the final output, clear the history
            for (int k = 1; k < ntaps; k++)
            begin
                o.res = tap_sum_shift('0);
                o.lst = (k == ntaps - 1);
                outs.insert(outs.size(), o);
            end
            for (int k = 0; k < HIST_LEN; k++)
                hist[k] = '0;
        end
        if (r.chk)
        begin
            outs[0].res = r.want_res;
            outs[0].lst = r.want_lst;
        end
        foreach (outs[i])
            add_expect(outs[i]);
    endtask

    task automatic push_sample(input stim_row_t r);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= r.val;
        s_axis_tlast  <= r.lst;
        do
            @(posedge clk);
        while (!s_axis_tready);
        queue_results(r);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_TAP_COUNT)
            taps_reg = val[TAPS_W-1:0];
        else
            coef_reg[idx - REG_COEF_0] = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // drop the input, let every expected output arrive, then let the pipe settle
    task automatic quiesce();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (conv_out_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_config();
        int n;
        quiesce();
        if ($urandom_range(1) == 0)
        begin
            write_reg(REG_TAP_COUNT, 16'($urandom));
            for (int k = 0; k < MAX_TAPS; k++)
                write_reg(REG_COEF_0 + CFG_IDX_W'(k), rand_word());
        end
        else
        begin
            n = $urandom_range(1, 3);
            repeat (n) write_reg(CFG_IDX_W'($urandom_range(MAX_TAPS)), 16'($urandom));
        end
    endtask

    task automatic note_failure(input string msg);
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
    endtask

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        conv_out_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (conv_out_q.size() == 0)
                note_failure($sformatf("output with nothing pending: tdata %h last %b",
                                       m_axis_tdata, m_axis_tlast));
            else
            begin
                want = conv_out_q.pop_front();
                if (m_axis_tdata !== OUT_TDATA_W'(want.res) || m_axis_tlast !== want.lst)
                    note_failure($sformatf("mismatch: expected tdata %h last %b, got %h last %b",
                                           OUT_TDATA_W'(want.res), want.lst,
                                           m_axis_tdata, m_axis_tlast));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            stall_cnt = 0;
        else
            stall_cnt++;
        if (stall_cnt >= STALL_LIMIT)
        begin
            $display("linear_convolution_fir_unit verification failed");
            $finish;
        end
    end

    initial
    begin
        bit prev_smp;
        int sent;
        int len;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        send_idle_pct = 21;
        recv_idle_pct = 82;
        prev_smp      = 1'b0;

        taps_reg = TAPS_W'(5);
        for (int k = 0; k < MAX_TAPS; k++)
            coef_reg[k] = '0;
        for (int k = 0; k < HIST_LEN; k++)
            hist[k] = '0;

        // coefficients zero after reset
        add_row(r_smp(16'h7FFF, 1'b0, 1'b1, '0, 1'b0));
        add_row(r_smp(16'h8000, 1'b1, 1'b1, '0, 1'b0));
        // single tap, most negative coefficient
        add_row(r_cfg(REG_TAP_COUNT, 16'd1));
        add_row(r_cfg(REG_COEF_0, 16'h8000));
        add_row(r_smp(16'h8000, 1'b0, 1'b1, 34'sd1073741824, 1'b0));
        add_row(r_smp(16'h7FFF, 1'b1, 1'b1, -34'sd1073709056, 1'b1));
        // tap count zero acts as one tap; upper data bits are ignored
        add_row(r_cfg(REG_TAP_COUNT, 16'hFFF8));
        add_row(r_cfg(REG_COEF_0, 16'h7FFF));
        add_row(r_smp(16'h8000, 1'b1, 1'b1, -34'sd1073709056, 1'b1));
        // all seven taps at the negative extreme: largest positive sum
        add_row(r_cfg(REG_TAP_COUNT, 16'd7));
        for (int k = 0; k < MAX_TAPS; k++)
            add_row(r_cfg(REG_COEF_0 + CFG_IDX_W'(k), 16'h8000));
        for (int k = 0; k < MAX_TAPS - 1; k++)
            add_row(r_smp(16'h8000, 1'b0));
        add_row(r_smp(16'h8000, 1'b1, 1'b1, 34'sd7516192768, 1'b0));
        // positive extreme coefficients: most negative sum
        for (int k = 0; k < MAX_TAPS; k++)
            add_row(r_cfg(REG_COEF_0 + CFG_IDX_W'(k), 16'h7FFF));
        for (int k = 0; k < MAX_TAPS - 1; k++)
            add_row(r_smp(16'h8000, 1'b0));
        add_row(r_smp(16'h8000, 1'b1, 1'b1, -34'sd7515963392, 1'b0));
        // three taps; unused coefficients must not contribute
        add_row(r_cfg(REG_TAP_COUNT, 16'd3));
        add_row(r_cfg(REG_COEF_0, 16'd1));
        add_row(r_cfg(REG_COEF_0 + CFG_IDX_W'(1), 16'hFFFE));
        add_row(r_cfg(REG_COEF_0 + CFG_IDX_W'(2), 16'd3));
        for (int k = 3; k < MAX_TAPS; k++)
            add_row(r_cfg(REG_COEF_0 + CFG_IDX_W'(k), 16'h1234));
        add_row(r_smp(16'd5, 1'b0));
        add_row(r_smp(16'hFFFF, 1'b0));
        add_row(r_smp(16'd100, 1'b1));
        // change the tap count in the middle of a run
        add_row(r_smp(16'd10, 1'b0));
        add_row(r_cfg(REG_TAP_COUNT, 16'd6));
        add_row(r_smp(16'd20, 1'b0));
        add_row(r_smp(16'hFFF9, 1'b1));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].kind == ROW_CFG)
            begin
                if (prev_smp)
                    quiesce();
                write_reg(dir_tab[i].idx, dir_tab[i].val);
                prev_smp = 1'b0;
            end
            else
            begin
                push_sample(dir_tab[i]);
                prev_smp = 1'b1;
            end
        end

        for (int mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0: begin send_idle_pct = 21; recv_idle_pct = 82; end
                1: begin send_idle_pct = 82; recv_idle_pct = 21; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            sent = 0;
            while (sent < RAND_ITEMS_PER_MODE)
            begin
                if ($urandom_range(3) == 0)
                    random_config();
                len = ($urandom_range(9) == 0) ? $urandom_range(5, 14) : $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                begin
                    if (i != 0 && $urandom_range(11) == 0)
                        random_config();
                    push_sample(r_smp(rand_word(), i == len - 1));
                end
                sent += len;
            end
        end

        quiesce();
        if (fail_cnt == 0 && conv_out_q.size() == 0)
            $display("linear_convolution_fir_unit verification clean");
        else
            $display("linear_convolution_fir_unit verification failed");
        $finish;
    end

endmodule
